// File: hw/rtl/mnp_pkg.sv
// ----------------------------------------------------------------------------
// mnp_pkg: shared types and constants for the music-notation note parser
// Parse modes, the parser state record, the event record, character codes
// and the letter lookup tables.
// ----------------------------------------------------------------------------
package mnp_pkg;

  // Parse modes, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE   = 8'b0000_0001,
    MODE_OCT    = 8'b0000_0010,
    MODE_ACC    = 8'b0000_0100,
    MODE_DUR    = 8'b0000_1000,
    MODE_DOT    = 8'b0001_0000,
    MODE_KSIGN  = 8'b0010_0000,
    MODE_KNOTE  = 8'b0100_0000,
    MODE_KCLOSE = 8'b1000_0000
  } mode_t;

  // Key-signature entry: -1 flat, 0 none, +1 sharp
  typedef logic signed [1:0] key_t;

  localparam key_t KEY_NONE  = 2'sb00;
  localparam key_t KEY_SHARP = 2'sb01;
  localparam key_t KEY_FLAT  = 2'sb11;

  // Parser state carried from one character to the next
  typedef struct packed {
    mode_t             mode;
    logic signed [6:0] pitch;
    logic [2:0]        letter;
    logic              rest;
    key_t [6:0]        key_table;
    key_t              key_sign;
    logic [11:0]       held;
  } parse_st_t;

  // One note or rest event
  typedef struct packed {
    logic signed [6:0] note_number;
    logic              is_rest;
    logic [11:0]       duration_ticks;
    logic [2:0]        lamp_index;
  } note_evt_t;

  // Character codes
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_FLAT  = 8'h40;
  localparam logic [7:0] CH_NAT   = 8'h24;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_D1    = 8'h31;
  localparam logic [7:0] CH_D2    = 8'h32;
  localparam logic [7:0] CH_D4    = 8'h34;
  localparam logic [7:0] CH_D6    = 8'h36;
  localparam logic [7:0] CH_D8    = 8'h38;

  localparam logic [6:0]  BASE_RESET = 7'd8;
  localparam logic [11:0] HELD_RESET = 12'd8;
  localparam logic [11:0] DUR_MAX    = 12'hFFF;
  localparam logic signed [6:0] OCTAVE = 7'sd12;

  // Semitone number of a letter, A=0 .. G=6
  function automatic logic signed [6:0] letter_pitch(input logic [2:0] idx);
    logic signed [6:0] p;
    case (idx)
      3'd0:    p = 7'sd21;
      3'd1:    p = 7'sd23;
      3'd2:    p = 7'sd12;
      3'd3:    p = 7'sd14;
      3'd4:    p = 7'sd16;
      3'd5:    p = 7'sd17;
      3'd6:    p = 7'sd19;
      default: p = 7'sd0;
    endcase
    return p;
  endfunction

  // Lamp of a letter: C..G on 0..4, A on 6, B on 7
  function automatic logic [2:0] letter_lamp(input logic [2:0] idx);
    logic [2:0] l;
    case (idx)
      3'd0:    l = 3'd6;
      3'd1:    l = 3'd7;
      3'd2:    l = 3'd0;
      3'd3:    l = 3'd1;
      3'd4:    l = 3'd2;
      3'd5:    l = 3'd3;
      3'd6:    l = 3'd4;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

endpackage

// File: hw/rtl/mnp_ifs.sv
// ----------------------------------------------------------------------------
// mnp_ifs: valid/ready channels of the note parser
// Character channel in, note event channel out.
// ----------------------------------------------------------------------------
interface mnp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface mnp_note_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] note_number;
  logic              is_rest;
  logic [11:0]       duration_ticks;
  logic [2:0]        lamp_index;

  modport source (output valid, output note_number, output is_rest,
                  output duration_ticks, output lamp_index, input ready);
  modport sink   (input valid, input note_number, input is_rest,
                  input duration_ticks, input lamp_index, output ready);
endinterface

// File: hw/rtl/mnp_step.sv
// ----------------------------------------------------------------------------
// mnp_step: next-state logic for one character
// Walks the parse modes in order for one character: a character that does
// not continue the current note closes it and is parsed again from idle.
// ----------------------------------------------------------------------------
module mnp_step
  import mnp_pkg::*;
(
  input  parse_st_t  cur,
  input  logic [7:0] ch,
  input  logic [6:0] base_ticks,
  output parse_st_t  nxt,
  output logic       emit,
  output note_evt_t  evt
);

  always_comb begin
    logic go_acc;
    logic go_dur;
    logic go_dot;
    logic go_idle;
    logic is_letter;
    key_t key;
    logic signed [6:0] key_ext;
    logic [13:0] dur_x3;
    logic [12:0] dur_dot;

    nxt       = cur;
    emit      = 1'b0;
    evt       = '0;
    go_acc    = 1'b0;
    go_dur    = 1'b0;
    go_dot    = 1'b0;
    go_idle   = 1'b0;
    is_letter = (ch >= CH_A) && (ch <= CH_G);
    key       = cur.key_table[cur.letter];
    key_ext   = {{5{key[1]}}, key};
    dur_x3    = {2'b00, cur.held} + {1'b0, cur.held, 1'b0};
    dur_dot   = dur_x3[13:1];

    // entry point by current mode
    case (cur.mode)
      MODE_IDLE: go_idle = 1'b1;
      MODE_OCT: begin
        if (ch == CH_PLUS) begin
          nxt.pitch = cur.pitch + OCTAVE;
          nxt.mode  = MODE_ACC;
        end else if (ch == CH_MINUS) begin
          nxt.pitch = cur.pitch - OCTAVE;
          nxt.mode  = MODE_ACC;
        end else begin
          go_acc = 1'b1;
        end
      end
      MODE_ACC: go_acc = 1'b1;
      MODE_DUR: go_dur = 1'b1;
      MODE_DOT: go_dot = 1'b1;
      MODE_KSIGN: begin
        if (ch == CH_SHARP) begin
          nxt.key_sign = KEY_SHARP;
          nxt.mode     = MODE_KNOTE;
        end else if (ch == CH_FLAT) begin
          nxt.key_sign = KEY_FLAT;
          nxt.mode     = MODE_KNOTE;
        end else begin
          // closing character swallowed
          nxt.mode = MODE_IDLE;
        end
      end
      MODE_KNOTE: begin
        if (is_letter) begin
          nxt.key_table[3'(ch - CH_A)] = cur.key_sign;
        end else begin
          nxt.mode = MODE_IDLE;
        end
      end
      MODE_KCLOSE: nxt.mode = MODE_IDLE;
      default:     nxt.mode = MODE_IDLE;
    endcase

    // key signature and accidental
    if (go_acc) begin
      nxt.pitch = nxt.pitch + key_ext;
      nxt.mode  = MODE_DUR;
      if (ch == CH_SHARP) begin
        if (key != KEY_SHARP) nxt.pitch = nxt.pitch + 7'sd1;
      end else if (ch == CH_FLAT) begin
        if (key != KEY_FLAT) nxt.pitch = nxt.pitch - 7'sd1;
      end else if (ch == CH_NAT) begin
        nxt.pitch = nxt.pitch - key_ext;
      end else begin
        go_dur = 1'b1;
      end
    end

    // duration digit
    if (go_dur) begin
      nxt.mode = MODE_DOT;
      case (ch)
        CH_D1:   nxt.held = {base_ticks, 5'b0};
        CH_D2:   nxt.held = {1'b0, base_ticks, 4'b0};
        CH_D4:   nxt.held = {2'b0, base_ticks, 3'b0};
        CH_D8:   nxt.held = {3'b0, base_ticks, 2'b0};
        CH_D6:   nxt.held = {4'b0, base_ticks, 1'b0};
        default: go_dot = 1'b1;
      endcase
    end

    // dot and event
    if (go_dot) begin
      emit     = 1'b1;
      nxt.mode = MODE_IDLE;
      if (ch == CH_DOT) begin
        evt.duration_ticks = dur_dot[12] ? DUR_MAX : dur_dot[11:0];
      end else begin
        evt.duration_ticks = cur.held;
        go_idle            = 1'b1;
      end
      evt.is_rest     = cur.rest;
      evt.note_number = cur.rest ? 7'sd0 : nxt.pitch;
      evt.lamp_index  = cur.rest ? 3'd0 : letter_lamp(cur.letter);
    end

    // start of a note, rest or key group
    if (go_idle) begin
      if (is_letter) begin
        nxt.letter = 3'(ch - CH_A);
        nxt.pitch  = letter_pitch(3'(ch - CH_A));
        nxt.rest   = 1'b0;
        nxt.mode   = MODE_OCT;
      end else if (ch == CH_P) begin
        nxt.pitch = 7'sd0;
        nxt.rest  = 1'b1;
        nxt.mode  = MODE_DUR;
      end else if (ch == CH_LBRK) begin
        nxt.key_table = '0;
        nxt.mode      = MODE_KSIGN;
      end
    end
  end

endmodule

// File: hw/rtl/music_notation_note_parser.sv
// ----------------------------------------------------------------------------
// music_notation_note_parser: streaming note parser
// Turns a song string, one character per beat, into note and rest events.
// ----------------------------------------------------------------------------
// Takes one character per clock but for the stall below. An accepted character
// is held in the input register and resolved against the parser state at the
// edge at which it fires; if it closes a note, the event lands in the output
// register at that edge and is offered from there. The rate is one character
// every clock, with a stall only when a character would close a note while the
// previous event is still held in the output register and the receiver is not
// ready. cfg_data sets the base tick count (reset 8), and the shortest note,
// digit 6, lasts twice that; write it only while no character is in flight.
module music_notation_note_parser
  import mnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  mnp_char_if.sink   in_chan,
  mnp_note_if.source out_chan
);

  logic       base_r;
  logic [6:0] base_ticks_r;
  logic       s0_v_r;
  logic [7:0] s0_ch_r;
  parse_st_t  st_r;
  parse_st_t  st_nxt;
  logic       emit;
  note_evt_t  evt;
  logic       s0_fire;
  logic       out_v_r;
  note_evt_t  out_evt_r;

  // resolve the held character
  mnp_step u_step (
    .cur        (st_r),
    .ch         (s0_ch_r),
    .base_ticks (base_ticks_r),
    .nxt        (st_nxt),
    .emit       (emit),
    .evt        (evt)
  );

  assign s0_fire       = s0_v_r && (!emit || !out_v_r || out_chan.ready);
  assign in_chan.ready = !s0_v_r || s0_fire;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ticks_r <= BASE_RESET;
      base_r       <= 1'b0;
    end else begin
      base_r <= cfg_we;
      if (cfg_we) base_ticks_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s0_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) s0_ch_r <= in_chan.ch;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= MODE_IDLE;
      st_r.pitch     <= 7'sd0;
      st_r.letter    <= 3'd0;
      st_r.rest      <= 1'b0;
      st_r.key_table <= '0;
      st_r.key_sign  <= KEY_NONE;
      st_r.held      <= HELD_RESET;
    end else if (s0_fire) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s0_fire && emit) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && emit) out_evt_r <= evt;
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.note_number    = out_evt_r.note_number;
  assign out_chan.is_rest        = out_evt_r.is_rest;
  assign out_chan.duration_ticks = out_evt_r.duration_ticks;
  assign out_chan.lamp_index     = out_evt_r.lamp_index;

`ifndef SYNTHESIS
  // key letters are only taken once a sign is known
  a_knote_sign: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_KNOTE |-> st_r.key_sign != KEY_NONE)
    else $error("key letter mode without a key sign");

  // a rest carries no pitch or lamp
  a_rest_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_evt_r.is_rest |-> out_evt_r.note_number == 7'sd0 &&
      out_evt_r.lamp_index == 3'd0)
    else $error("rest event with pitch or lamp set");

  // a held character stalls only behind a full, blocked output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    s0_v_r && !s0_fire |-> out_v_r && !out_chan.ready && emit)
    else $error("input stage stalled without output backpressure");

  // a config write lands in the register at the edge that takes it
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    base_r |-> base_ticks_r == $past(cfg_data))
    else $error("base tick register missed a write");
`endif

endmodule

// File: tb/sv/note_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_event_checker: scoreboard for the music-notation note parser
// Watches the character and event channels, runs a parser model of its own
// on every accepted character and compares each event beat with the oldest
// predicted event. Hands the failure count and the number of events still
// due to the testbench top.
// ----------------------------------------------------------------------------
module note_event_checker
  import mnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  mnp_char_if        char_mon,
  mnp_note_if        note_mon,
  output int         fail_count,
  output int         pending
);

  // Parser model state
  mode_t cur_mode;
  int    tone;
  int    letter_no;
  bit    rest_flag;
  key_t  key_map [7];
  key_t  group_sign;
  int    base_len;
  int    hold_len;

  // Semitone and lamp of each letter, A first
  int tone_table [7] = '{21, 23, 12, 14, 16, 17, 19};
  int lamp_table [7] = '{6, 7, 0, 1, 2, 3, 4};

  note_evt_t due_events [$];
  int        errors  = 0;
  int        waiting = 0;

  assign fail_count = errors;
  assign pending    = waiting;

  function automatic int clip_ticks(input int v);
    return (v > int'(DUR_MAX)) ? int'(DUR_MAX) : v;
  endfunction

  function automatic void clear_parser();
    cur_mode   = MODE_IDLE;
    tone       = 0;
    letter_no  = 0;
    rest_flag  = 1'b0;
    group_sign = KEY_NONE;
    base_len   = int'(BASE_RESET);
    hold_len   = int'(HELD_RESET);
    foreach (key_map[i]) key_map[i] = KEY_NONE;
  endfunction

  // Feed one character; a character that ends a note falls through the
  // remaining stages and is then parsed again from idle
  function automatic bit advance_parser(input logic [7:0] c, output note_evt_t ev);
    bit consumed;
    bit emitted;
    int key;
    int len;
    int lamp;
    consumed = 1'b0;
    emitted  = 1'b0;
    ev       = '0;
    while (!consumed) begin
      case (cur_mode)
        MODE_IDLE: begin
          consumed = 1'b1;
          if (c >= CH_A && c <= CH_G) begin
            letter_no = int'(c - CH_A);
            tone      = tone_table[letter_no];
            rest_flag = 1'b0;
            cur_mode  = MODE_OCT;
          end else if (c == CH_P) begin
            tone      = 0;
            rest_flag = 1'b1;
            cur_mode  = MODE_DUR;
          end else if (c == CH_LBRK) begin
            foreach (key_map[i]) key_map[i] = KEY_NONE;
            cur_mode = MODE_KSIGN;
          end
        end
        MODE_OCT: begin
          if (c == CH_PLUS) begin
            tone     = tone + 12;
            consumed = 1'b1;
          end else if (c == CH_MINUS) begin
            tone     = tone - 12;
            consumed = 1'b1;
          end
          cur_mode = MODE_ACC;
        end
        MODE_ACC: begin
          // key entry is added first; accidentals adjust on top of it, a natural cancels it
          key  = int'(key_map[letter_no]);
          tone = tone + key;
          if (c == CH_SHARP) begin
            consumed = 1'b1;
            if (key_map[letter_no] != KEY_SHARP) tone = tone + 1;
          end else if (c == CH_FLAT) begin
            consumed = 1'b1;
            if (key_map[letter_no] != KEY_FLAT) tone = tone - 1;
          end else if (c == CH_NAT) begin
            consumed = 1'b1;
            tone     = tone - key;
          end
          cur_mode = MODE_DUR;
        end
        MODE_DUR: begin
          consumed = 1'b1;
          case (c)
            CH_D1:   hold_len = clip_ticks(base_len * 32);
            CH_D2:   hold_len = clip_ticks(base_len * 16);
            CH_D4:   hold_len = clip_ticks(base_len * 8);
            CH_D8:   hold_len = clip_ticks(base_len * 4);
            CH_D6:   hold_len = clip_ticks(base_len * 2);
            default: consumed = 1'b0;
          endcase
          cur_mode = MODE_DOT;
        end
        MODE_DOT: begin
          // dot scales this event only
          if (c == CH_DOT) begin
            consumed = 1'b1;
            len      = clip_ticks(hold_len * 3 / 2);
          end else begin
            len = hold_len;
          end
          lamp              = rest_flag ? 0 : lamp_table[letter_no];
          ev.note_number    = rest_flag ? 7'sd0 : tone[6:0];
          ev.is_rest        = rest_flag;
          ev.duration_ticks = len[11:0];
          ev.lamp_index     = lamp[2:0];
          emitted           = 1'b1;
          cur_mode          = MODE_IDLE;
        end
        MODE_KSIGN: begin
          if (c == CH_SHARP) begin
            group_sign = KEY_SHARP;
            consumed   = 1'b1;
            cur_mode   = MODE_KNOTE;
          end else if (c == CH_FLAT) begin
            group_sign = KEY_FLAT;
            consumed   = 1'b1;
            cur_mode   = MODE_KNOTE;
          end else begin
            cur_mode = MODE_KCLOSE;
          end
        end
        MODE_KNOTE: begin
          if (c >= CH_A && c <= CH_G) begin
            key_map[c - CH_A] = group_sign;
            consumed          = 1'b1;
          end else begin
            cur_mode = MODE_KCLOSE;
          end
        end
        default: begin
          // closing character of a key group, swallowed whatever it is
          consumed = 1'b1;
          cur_mode = MODE_IDLE;
        end
      endcase
    end
    return emitted;
  endfunction

  // Compare event beats first, then model the character beat of this edge
  always @(posedge clk) begin : watch
    note_evt_t want;
    note_evt_t got;
    if (!rst_n) begin
      clear_parser();
      due_events.delete();
    end else begin
      if (cfg_we) base_len = int'(cfg_data);
      if (note_mon.valid && note_mon.ready) begin
        got.note_number    = note_mon.note_number;
        got.is_rest        = note_mon.is_rest;
        got.duration_ticks = note_mon.duration_ticks;
        got.lamp_index     = note_mon.lamp_index;
        if (due_events.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t unexpected event: note=%0d rest=%0d dur=%0d lamp=%0d", $realtime,
                     got.note_number, got.is_rest, got.duration_ticks, got.lamp_index);
        end else begin
          want = due_events.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $write("%0t event mismatch: exp note=%0d rest=%0d dur=%0d lamp=%0d,", $realtime,
                     want.note_number, want.is_rest, want.duration_ticks, want.lamp_index);
              $display(" got note=%0d rest=%0d dur=%0d lamp=%0d",
                       got.note_number, got.is_rest, got.duration_ticks, got.lamp_index);
            end
          end
        end
      end
      if (char_mon.valid && char_mon.ready) begin
        if (advance_parser(char_mon.ch, want)) due_events.push_back(want);
      end
    end
    waiting = due_events.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the music-notation note parser
// Streams a directed song and then random notes, rests, key groups and noise
// through the parser under several tick settings and idle patterns, with a
// long output hold-off to back up the input. The checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mnp_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 120;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_HIGH = 8'hFF;
  localparam logic [7:0] CH_RBRK = 8'h5D;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_F    = 8'h46;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_data;
  int         fail_count;
  int         pending;

  // Idle control shared with the receiver process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_hold     = 0;
  int items_sent     = 0;

  logic [7:0] digit_codes  [5] = '{CH_D1, CH_D2, CH_D4, CH_D8, CH_D6};
  logic [7:0] accent_codes [3] = '{CH_SHARP, CH_FLAT, CH_NAT};

  // Opening song: key group closed by 0xFF, sharp under sharp key, top note,
  // rest, flat key on C, lowest note, natural, reused length, end byte
  logic [7:0] opening [28] = '{
    CH_LBRK, CH_SHARP, CH_F, CH_C, CH_HIGH,
    CH_C, CH_SHARP, CH_D4, CH_DOT,
    CH_B, CH_PLUS, CH_SHARP, CH_D1,
    CH_P, CH_D6,
    CH_LBRK, CH_FLAT, CH_C, CH_RBRK,
    CH_C, CH_MINUS, CH_FLAT, CH_D8,
    CH_C, CH_NAT, CH_D2,
    CH_G, CH_NUL
  };

  mnp_char_if in_chan ();
  mnp_note_if out_chan ();

  music_notation_note_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  note_event_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .char_mon   (in_chan),
    .note_mon   (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Event receiver: long hold-off when asked, random stalls otherwise
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One character beat; called and returns at a falling edge
  task automatic send_char(input logic [7:0] c);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  // Sender pause until every predicted event has come out
  task automatic drain_events();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_base(input logic [6:0] v);
    drain_events();
    // let a character that closed nothing settle in the parser
    repeat (8) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Optional length digit and dot
  task automatic send_length();
    if ($urandom_range(9) < 7) send_char(digit_codes[$urandom_range(4)]);
    if ($urandom_range(9) < 3) send_char(CH_DOT);
  endtask

  // Mostly well-formed notes, rests and key groups, some end bytes and noise
  task automatic send_token();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 58) begin
      send_char(CH_A + 8'($urandom_range(6)));
      if ($urandom_range(1) == 1) send_char(($urandom_range(1) == 1) ? CH_PLUS : CH_MINUS);
      if ($urandom_range(1) == 1) send_char(accent_codes[$urandom_range(2)]);
      send_length();
    end else if (pick < 70) begin
      send_char(CH_P);
      send_length();
    end else if (pick < 80) begin
      send_char(CH_LBRK);
      if ($urandom_range(4) != 0) send_char(($urandom_range(1) == 1) ? CH_SHARP : CH_FLAT);
      n = $urandom_range(4);
      repeat (n) send_char(CH_A + 8'($urandom_range(6)));
      send_char(($urandom_range(3) != 0) ? CH_RBRK : 8'($urandom_range(255)));
    end else if (pick < 88) begin
      send_char(CH_NUL);
    end else begin
      send_char(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal           = items_sent + n_items;
    while (items_sent < goal) send_token();
  endtask

  // Stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = BASE_RESET;
    in_chan.valid = 1'b0;
    in_chan.ch    = CH_NUL;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed song at the reset tick setting
    foreach (opening[i]) send_char(opening[i]);

    // random phases over the tick extremes
    write_base(7'd1);
    run_phase(0, 0, ITEMS_PER_PHASE);
    write_base(7'd64);
    run_phase(85, 0, ITEMS_PER_PHASE);
    write_base(7'd127);
    run_phase(0, 85, ITEMS_PER_PHASE);
    write_base(7'd0);
    run_phase(38, 38, ITEMS_PER_PHASE);

    // back-to-back notes against a held receiver, then a full pause
    write_base(BASE_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_hold     = 80;
    repeat (20) begin
      send_char(CH_A + 8'($urandom_range(6)));
      send_char(CH_D4);
    end
    drain_events();

    write_base(7'($urandom_range(64, 1)));
    run_phase(20, 20, 60);

    // close any open note, then let the last events out
    send_char(CH_NUL);
    drain_events();
    repeat (10) @(negedge clk);

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mnp_pkg.sv
hw/rtl/mnp_ifs.sv
hw/rtl/mnp_step.sv
hw/rtl/music_notation_note_parser.sv
tb/sv/note_event_checker.sv
tb/sv/tb_top.sv
